>>> rtl/core/vhst_pkg.sv
// ----------------------------------------------------------------------------
// vhst_pkg: shared types and constants of the versioned handle slot table
// Word layouts of the channels, operation and status codes, sequencer
// states and the operand and result bundles of the shared ALU.
// ----------------------------------------------------------------------------
package vhst_pkg;

  localparam int unsigned INDEX_BITS = 10;
  localparam int unsigned MAX_SLOTS  = 1023;
  localparam int unsigned SLOT_DEPTH = MAX_SLOTS + 1;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned STATUS_W   = 2;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [ID_W-1:0]       id_t;
  typedef logic [FUNC_W-1:0]     func_t;
  typedef logic [STATUS_W-1:0]   status_t;

  // one version step sits just above the slot index bits
  localparam id_t VER_STEP = id_t'(2 ** INDEX_BITS);

  localparam func_t FUNC_ADD      = 3'd0;
  localparam func_t FUNC_REMOVE   = 3'd1;
  localparam func_t FUNC_CONTAINS = 3'd2;
  localparam func_t FUNC_LOOKUP   = 3'd3;
  localparam func_t FUNC_ID_AT    = 3'd4;

  localparam status_t STATUS_OK     = 2'd0;
  localparam status_t STATUS_FULL   = 2'd1;
  localparam status_t STATUS_ABSENT = 2'd2;
  localparam status_t STATUS_RANGE  = 2'd3;

  typedef struct packed {
    func_t func;
    id_t   handle_id;
    idx_t  dense_index;
  } req_t;

  typedef struct packed {
    status_t status;
    id_t     result_id;
    logic    found;
    idx_t    entry_index;
    idx_t    move_from;
    idx_t    move_to;
    logic    moved;
    idx_t    live_count;
    logic    is_full;
  } rsp_t;

  typedef struct packed {
    id_t  a;
    id_t  b;
    logic sub;
  } alu_req_t;

  typedef struct packed {
    id_t  sum;
    logic eq;
    logic lt;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_EXEC,
    S_BUMP,
    S_LAST,
    S_MOVE,
    S_FIN
  } state_e;

endpackage

>>> rtl/core/vhst_chan_if.sv
// ----------------------------------------------------------------------------
// vhst_chan_if: valid/ready channel
// Carries one word of type T from a source to a sink.
// ----------------------------------------------------------------------------
interface vhst_chan_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> rtl/core/vhst_ram.sv
// ----------------------------------------------------------------------------
// vhst_ram: generic single-write, single-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old word.
// ----------------------------------------------------------------------------
module vhst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/vhst_alu.sv
// ----------------------------------------------------------------------------
// vhst_alu: shared add/subtract and compare unit
// Gives the sum or difference of two words together with equal and
// unsigned less-than flags; the sequencer picks what it needs each cycle.
// ----------------------------------------------------------------------------
module vhst_alu (
  input  vhst_pkg::alu_req_t req_i,
  output vhst_pkg::alu_rsp_t rsp_o
);
  import vhst_pkg::*;

  always_comb begin
    rsp_o.sum = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);
    rsp_o.eq  = (req_i.a == req_i.b);
    rsp_o.lt  = (req_i.a < req_i.b);
  end

endmodule

>>> rtl/core/versioned_handle_slot_table_unit.sv
// ----------------------------------------------------------------------------
// versioned_handle_slot_table_unit: slot map with versioned 32-bit IDs
// Packed array of live entries behind an indirection store, FIFO free list
// threaded through the link store, one operation at a time.
//
//   channel | dir | word                                   | taken when
//   --------+-----+----------------------------------------+------------------
//   cfg_i   | in  | usable slot count (10 b)               | valid & ready
//   req_i   | in  | func, handle_id, dense_index           | valid & ready
//   rsp_o   | out | status, result_id, found, entry_index, | valid & ready
//           |     | move_from, move_to, moved, live_count, |
//           |     | is_full                                |
//
// From accept to result load the sequencer passes S_CHECK, S_FIN for an early
// reject or an unused code; S_CHECK, S_EXEC, S_FIN for add, contains, lookup,
// id_at and a remove of a stale ID; S_CHECK, S_EXEC, S_BUMP, S_LAST, S_MOVE,
// S_FIN for a live remove. req_i is ready again the cycle after the load. Reset
// and every capacity write start a clearing pass of the version and link stores;
// req_i is not ready until it ends. A held rsp_o word stalls only the final load.
// ----------------------------------------------------------------------------
module versioned_handle_slot_table_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  vhst_chan_if.sink        cfg_i,
  vhst_chan_if.sink        req_i,
  vhst_chan_if.source      rsp_o
);
  import vhst_pkg::*;

  state_e   state_q, state_d;
  idx_t     clr_q, clr_d;
  idx_t     cap_q, cap_d;
  idx_t     count_q, count_d;
  idx_t     head_q, head_d;
  idx_t     tail_q, tail_d;
  idx_t     hole_q, hole_d;
  req_t     req_q, req_d;
  rsp_t     res_q, res_d;
  rsp_t     out_q, out_d;
  logic     out_vld_q, out_vld_d;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic     ver_we, lnk_we, dns_we;
  idx_t     ver_waddr, lnk_waddr, dns_waddr;
  idx_t     ver_raddr, lnk_raddr, dns_raddr;
  id_t      ver_wdata, dns_wdata;
  idx_t     lnk_wdata;
  id_t      ver_rd, dns_rd;
  idx_t     lnk_rd;
  idx_t     id_slot;

  vhst_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  vhst_ram #(.WIDTH(ID_W), .DEPTH(SLOT_DEPTH)) u_ver_ram (
    .clk_i   (clk_i),
    .we_i    (ver_we),
    .waddr_i (ver_waddr),
    .wdata_i (ver_wdata),
    .raddr_i (ver_raddr),
    .rdata_o (ver_rd)
  );

  vhst_ram #(.WIDTH(INDEX_BITS), .DEPTH(SLOT_DEPTH)) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .raddr_i (lnk_raddr),
    .rdata_o (lnk_rd)
  );

  vhst_ram #(.WIDTH(ID_W), .DEPTH(MAX_SLOTS)) u_dns_ram (
    .clk_i   (clk_i),
    .we_i    (dns_we),
    .waddr_i (dns_waddr),
    .wdata_i (dns_wdata),
    .raddr_i (dns_raddr),
    .rdata_o (dns_rd)
  );

  assign id_slot     = req_q.handle_id[INDEX_BITS-1:0];
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cap_d     = cap_q;
    count_d   = count_q;
    head_d    = head_q;
    tail_d    = tail_q;
    hole_d    = hole_q;
    req_d     = req_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;

    alu_req   = '0;
    ver_we    = 1'b0;
    lnk_we    = 1'b0;
    dns_we    = 1'b0;
    ver_waddr = id_slot;
    ver_wdata = '0;
    lnk_waddr = id_slot;
    lnk_wdata = '0;
    dns_waddr = count_q;
    dns_wdata = '0;
    ver_raddr = id_slot;
    lnk_raddr = id_slot;
    dns_raddr = req_q.dense_index;

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        // slot i holds version-zero id i and links to i + 1
        alu_req.a = id_t'(clr_q);
        alu_req.b = id_t'(1);
        ver_we    = 1'b1;
        ver_waddr = clr_q;
        ver_wdata = id_t'(clr_q);
        lnk_we    = 1'b1;
        lnk_waddr = clr_q;
        lnk_wdata = alu_rsp.sum[INDEX_BITS-1:0];
        clr_d     = alu_rsp.sum[INDEX_BITS-1:0];
        if (clr_q == idx_t'(SLOT_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_i.valid) begin
          req_d   = req_i.data;
          res_d   = '0;
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        if (req_q.func == FUNC_ADD) begin
          ver_raddr = head_q;
          lnk_raddr = head_q;
        end
        case (req_q.func)
          FUNC_ADD: begin
            alu_req.a = id_t'(count_q);
            alu_req.b = id_t'(cap_q);
            if (alu_rsp.lt) begin
              state_d = S_EXEC;
            end else begin
              res_d.status = STATUS_FULL;
              state_d      = S_FIN;
            end
          end
          FUNC_REMOVE, FUNC_CONTAINS, FUNC_LOOKUP: begin
            // slot beyond capacity can never be live
            alu_req.a = id_t'(cap_q);
            alu_req.b = id_t'(id_slot);
            if (alu_rsp.lt || (req_q.func == FUNC_REMOVE && count_q == '0)) begin
              if (req_q.func != FUNC_CONTAINS) begin
                res_d.status = STATUS_ABSENT;
              end
              state_d = S_FIN;
            end else begin
              state_d = S_EXEC;
            end
          end
          FUNC_ID_AT: begin
            alu_req.a = id_t'(req_q.dense_index);
            alu_req.b = id_t'(count_q);
            if (alu_rsp.lt) begin
              state_d = S_EXEC;
            end else begin
              res_d.status = STATUS_RANGE;
              state_d      = S_FIN;
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end

      S_EXEC: begin
        alu_req.a = ver_rd;
        alu_req.b = req_q.handle_id;
        state_d   = S_FIN;
        case (req_q.func)
          FUNC_ADD: begin
            // pop the free head, point its link at the new dense position
            head_d            = lnk_rd;
            lnk_we            = 1'b1;
            lnk_waddr         = head_q;
            lnk_wdata         = count_q;
            dns_we            = 1'b1;
            dns_waddr         = count_q;
            dns_wdata         = ver_rd;
            res_d.result_id   = ver_rd;
            res_d.entry_index = count_q;
            count_d           = count_q + idx_t'(1);
          end
          FUNC_REMOVE: begin
            if (alu_rsp.eq) begin
              // queue the slot at the free tail, remember the hole
              res_d.found = 1'b1;
              lnk_we      = 1'b1;
              lnk_waddr   = tail_q;
              lnk_wdata   = id_slot;
              tail_d      = id_slot;
              hole_d      = lnk_rd;
              state_d     = S_BUMP;
            end else begin
              res_d.status = STATUS_ABSENT;
            end
          end
          FUNC_CONTAINS: begin
            res_d.found = alu_rsp.eq;
          end
          FUNC_LOOKUP: begin
            if (alu_rsp.eq) begin
              res_d.found       = 1'b1;
              res_d.entry_index = lnk_rd;
            end else begin
              res_d.status = STATUS_ABSENT;
            end
          end
          FUNC_ID_AT: begin
            res_d.result_id = dns_rd;
          end
          default: begin
            res_d = res_q;
          end
        endcase
      end

      S_BUMP: begin
        // the stored id equals handle_id here; advance its version
        alu_req.a = req_q.handle_id;
        alu_req.b = VER_STEP;
        ver_we    = 1'b1;
        ver_waddr = id_slot;
        ver_wdata = alu_rsp.sum;
        state_d   = S_LAST;
      end

      S_LAST: begin
        alu_req.a   = id_t'(count_q);
        alu_req.b   = id_t'(1);
        alu_req.sub = 1'b1;
        count_d     = alu_rsp.sum[INDEX_BITS-1:0];
        dns_raddr   = alu_rsp.sum[INDEX_BITS-1:0];
        state_d     = S_MOVE;
      end

      S_MOVE: begin
        // move the last dense id into the hole and repoint its slot
        if (ID_W'(hole_q) < ID_W'(MAX_SLOTS)) begin
          dns_we = 1'b1;
        end
        dns_waddr       = hole_q;
        dns_wdata       = dns_rd;
        lnk_we          = 1'b1;
        lnk_waddr       = dns_rd[INDEX_BITS-1:0];
        lnk_wdata       = hole_q;
        res_d.move_from = count_q;
        res_d.move_to   = hole_q;
        res_d.moved     = 1'b1;
        state_d         = S_FIN;
      end

      S_FIN: begin
        alu_req.a = id_t'(count_q);
        alu_req.b = id_t'(cap_q);
        if (!out_vld_q || rsp_o.ready) begin
          out_d            = res_q;
          out_d.live_count = count_q;
          out_d.is_full    = alu_rsp.eq;
          out_vld_d        = 1'b1;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // capacity write reinitializes the table and restarts the clearing pass
    if (cfg_i.valid) begin
      cap_d   = cfg_i.data;
      tail_d  = cfg_i.data;
      count_d = '0;
      head_d  = '0;
      clr_d   = '0;
      state_d = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      cap_q     <= idx_t'(MAX_SLOTS);
      count_q   <= '0;
      head_q    <= '0;
      tail_q    <= idx_t'(MAX_SLOTS);
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cap_q     <= cap_d;
      count_q   <= count_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q <= hole_d;
    req_q  <= req_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule

>>> rtl/core/vhst_checker.sv
// ----------------------------------------------------------------------------
// vhst_checker: port-level checks of the slot table
// Watches the three channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module vhst_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           cfg_valid_i,
  input logic           cfg_ready_i,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input vhst_pkg::rsp_t rsp_data_i
);
  import vhst_pkg::*;

  // a waiting result word holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("result word changed while stalled");

  // a capacity write starts the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i |=> !req_ready_i)
    else $error("request taken right after capacity write");

  // one operation at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // a move only comes from a successful remove
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.moved |-> rsp_data_i.status == STATUS_OK && rsp_data_i.found)
    else $error("move reported without a successful remove");

  // a missing id reports nothing found, moved or handed out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.status == STATUS_ABSENT |->
      !rsp_data_i.found && !rsp_data_i.moved && rsp_data_i.result_id == '0)
    else $error("absent id with found, moved or id set");

endmodule

bind versioned_handle_slot_table_unit vhst_checker u_vhst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
